/* design/usg_pkg.sv */
// shared types, constants and term tables for the uv sphere grid point pipeline
// no dependencies
package usg_pkg;

    localparam int GRID_BITS = 10;
    localparam int FRAC_BITS = 14;
    localparam int OUT_W     = 16;
    localparam int IDX_W     = 20;
    localparam int PHASE_W   = 32;
    localparam int QUO_W     = GRID_BITS + PHASE_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    // step whose remainder decides rounding of the 16 bit texture fraction
    localparam int TAP_STEP  = GRID_BITS + OUT_W - 1;
    localparam int TERMS     = 7;
    localparam int TERM_W    = $clog2(TERMS);
    localparam int ANG_W     = 30;
    localparam int SER_W     = 31;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [31:0]      PI_Q30  = 32'd3373259426;
    localparam logic [SER_W-1:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_FACES_AROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FACES_POLE   = 1'b1;

    // term k divides by (2k)(2k+1) for sine and (2k-1)(2k) for cosine
    // quotient estimate (t * M) >> S, M = floor(2^S / D), S = 31 + clog2(D)
    localparam logic [7:0] SIN_D [TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
    localparam int         SIN_S [TERMS] = '{34, 36, 37, 38, 38, 39, 39};
    localparam logic [31:0] SIN_M [TERMS] = '{
        32'((64'd1 << 34) / 64'd6),   32'((64'd1 << 36) / 64'd20),
        32'((64'd1 << 37) / 64'd42),  32'((64'd1 << 38) / 64'd72),
        32'((64'd1 << 38) / 64'd110), 32'((64'd1 << 39) / 64'd156),
        32'((64'd1 << 39) / 64'd210)
    };
    localparam logic [7:0] COS_D [TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
    localparam int         COS_S [TERMS] = '{32, 35, 36, 37, 38, 39, 39};
    localparam logic [31:0] COS_M [TERMS] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 35) / 64'd12),
        32'((64'd1 << 36) / 64'd30),  32'((64'd1 << 37) / 64'd56),
        32'((64'd1 << 38) / 64'd90),  32'((64'd1 << 39) / 64'd132),
        32'((64'd1 << 39) / 64'd182)
    };

    typedef struct packed {
        logic [GRID_BITS-1:0] row;
        logic [GRID_BITS-1:0] column;
    } t_usg_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        logic signed [OUT_W-1:0] pos_z;
        logic [OUT_W-1:0]        tex_u;
        logic [OUT_W-1:0]        tex_v;
        logic [IDX_W-1:0]        vertex_index;
        logic                    face_valid;
        logic [IDX_W-1:0]        face_number;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
        logic [IDX_W-1:0]        corner_d;
    } t_usg_out;

    // per item data that rides along the pipeline
    typedef struct packed {
        logic [IDX_W-1:0] vi;
        logic [IDX_W-1:0] fnum;
        logic             fvalid;
        logic             pole_n;
        logic             pole_s;
        logic [OUT_W-1:0] tex_u;
        logic [OUT_W-1:0] tex_v;
    } t_usg_ctx;

    // one long division lane
    typedef struct packed {
        logic [GRID_BITS-1:0] num;
        logic [GRID_BITS-1:0] rem;
        logic [QUO_W-1:0]     quo;
        logic                 rbit;
    } t_usg_dlane;

    typedef struct packed {
        logic [SER_W-1:0] term;
        logic [ACC_W-1:0] pos;
        logic [ACC_W-1:0] neg;
    } t_usg_ser;

    typedef struct packed {
        logic [ANG_W-1:0] x2;
        t_usg_ser         sin;
        t_usg_ser         cos;
        logic [1:0]       quad;
        logic             swap;
    } t_usg_ang;

endpackage

/* design/usg_div_cell.sv */
// one restoring division step for the row and column lanes
// depends on usg_pkg
module usg_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [usg_pkg::STEP_W-1:0]  i_step,
    input  logic [usg_pkg::GRID_BITS-1:0] i_div_a,
    input  logic [usg_pkg::GRID_BITS-1:0] i_div_v,
    input  logic                        i_vld,
    input  usg_pkg::t_usg_ctx           i_ctx,
    input  usg_pkg::t_usg_dlane         i_row,
    input  usg_pkg::t_usg_dlane         i_col,
    output logic                        o_vld,
    output usg_pkg::t_usg_ctx           o_ctx,
    output usg_pkg::t_usg_dlane         o_row,
    output usg_pkg::t_usg_dlane         o_col
);
    import usg_pkg::*;

    function automatic t_usg_dlane div_step(input t_usg_dlane l,
                                            input logic [GRID_BITS-1:0] d,
                                            input logic tap);
        logic [GRID_BITS:0]   rem2;
        logic                 ge;
        logic [GRID_BITS-1:0] remn;
        t_usg_dlane           res;
        rem2 = {l.rem, l.num[GRID_BITS-1]};
        ge   = rem2 >= {1'b0, d};
        remn = ge ? GRID_BITS'(rem2 - {1'b0, d}) : rem2[GRID_BITS-1:0];
        res      = l;
        res.num  = l.num << 1;
        res.rem  = remn;
        res.quo  = {l.quo[QUO_W-2:0], ge};
        if (tap) begin
            res.rbit = ({1'b0, remn} + {2'b0, d[GRID_BITS-1:1]}) >= {1'b0, d};
        end
        return res;
    endfunction

    logic                r_vld;
    t_usg_ctx            r_ctx;
    t_usg_dlane          r_row;
    t_usg_dlane          r_col;
    logic                w_tap;

    assign w_tap = i_step == STEP_W'(TAP_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= i_ctx;
            r_row <= div_step(i_row, i_div_v, w_tap);
            r_col <= div_step(i_col, i_div_a, w_tap);
        end
    end

    assign o_vld = r_vld;
    assign o_ctx = r_ctx;
    assign o_row = r_row;
    assign o_col = r_col;

endmodule

/* design/usg_trig_cell.sv */
// one taylor term of sine and cosine for the polar and azimuth angles
// three register stages: multiply, reciprocal divide, correct and accumulate; depends on usg_pkg
module usg_trig_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [usg_pkg::TERM_W-1:0] i_term,
    input  logic                       i_vld,
    input  usg_pkg::t_usg_ctx          i_ctx,
    input  usg_pkg::t_usg_ang          i_pol,
    input  usg_pkg::t_usg_ang          i_azi,
    output logic                       o_vld,
    output usg_pkg::t_usg_ctx          o_ctx,
    output usg_pkg::t_usg_ang          o_pol,
    output usg_pkg::t_usg_ang          o_azi
);
    import usg_pkg::*;

    localparam int PROD_W = SER_W + ANG_W;
    localparam int TM_W   = SER_W + 32;
    localparam int QD_W   = SER_W + 8;

    logic [2:0]            r_vld;
    t_usg_ctx              r_a_ctx, r_b_ctx, r_c_ctx;
    t_usg_ang              r_a_pol, r_b_pol, r_c_pol;
    t_usg_ang              r_a_azi, r_b_azi, r_c_azi;
    logic [PROD_W-1:0]     r_a_prod [4];
    logic [SER_W-1:0]      r_b_t [4];
    logic [SER_W-1:0]      r_b_q [4];

    // lanes: polar sine, polar cosine, azimuth sine, azimuth cosine
    t_usg_ser              w_ser_in [4];
    t_usg_ser              w_ser_b [4];
    t_usg_ser              n_ser [4];
    logic [ANG_W-1:0]      w_x2 [4];
    logic [SER_W-1:0]      n_t [4];
    logic [SER_W-1:0]      n_q [4];
    t_usg_ang              n_pol;
    t_usg_ang              n_azi;
    logic                  w_sin_on;
    logic                  w_odd;

    assign w_sin_on = i_term < TERM_W'(TERMS - 1);
    assign w_odd    = !i_term[0];

    always_comb begin
        logic [TM_W-1:0]  tm;
        logic [QD_W-1:0]  qd;
        logic [SER_W-1:0] r;
        logic [SER_W-1:0] q;
        logic [7:0]       d;
        logic             on;
        w_ser_in[0] = i_pol.sin;
        w_ser_in[1] = i_pol.cos;
        w_ser_in[2] = i_azi.sin;
        w_ser_in[3] = i_azi.cos;
        w_x2[0] = i_pol.x2;
        w_x2[1] = i_pol.x2;
        w_x2[2] = i_azi.x2;
        w_x2[3] = i_azi.x2;
        w_ser_b[0] = r_b_pol.sin;
        w_ser_b[1] = r_b_pol.cos;
        w_ser_b[2] = r_b_azi.sin;
        w_ser_b[3] = r_b_azi.cos;
        for (int j = 0; j < 4; j++) begin
            n_t[j] = r_a_prod[j][PROD_W-1:ANG_W];
            if (j[0]) begin
                tm = TM_W'(n_t[j]) * TM_W'(COS_M[i_term]);
                n_q[j] = SER_W'(tm >> COS_S[i_term]);
                d  = COS_D[i_term];
                on = 1'b1;
            end else begin
                tm = TM_W'(n_t[j]) * TM_W'(SIN_M[i_term]);
                n_q[j] = SER_W'(tm >> SIN_S[i_term]);
                d  = SIN_D[i_term];
                on = w_sin_on;
            end
            // estimate is at most one short
            qd = QD_W'(r_b_q[j]) * QD_W'(d);
            r  = r_b_t[j] - qd[SER_W-1:0];
            q  = r_b_q[j] + SER_W'(r >= SER_W'(d));
            n_ser[j] = w_ser_b[j];
            if (on) begin
                n_ser[j].term = q;
                if (w_odd) begin
                    n_ser[j].neg = w_ser_b[j].neg + ACC_W'(q);
                end else begin
                    n_ser[j].pos = w_ser_b[j].pos + ACC_W'(q);
                end
            end
        end
        n_pol     = r_b_pol;
        n_pol.sin = n_ser[0];
        n_pol.cos = n_ser[1];
        n_azi     = r_b_azi;
        n_azi.sin = n_ser[2];
        n_azi.cos = n_ser[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctx <= i_ctx;
            r_a_pol <= i_pol;
            r_a_azi <= i_azi;
            for (int j = 0; j < 4; j++) begin
                r_a_prod[j] <= PROD_W'(w_ser_in[j].term) * PROD_W'(w_x2[j]);
            end
            r_b_ctx <= r_a_ctx;
            r_b_pol <= r_a_pol;
            r_b_azi <= r_a_azi;
            r_b_t   <= n_t;
            r_b_q   <= n_q;
            r_c_ctx <= r_b_ctx;
            r_c_pol <= n_pol;
            r_c_azi <= n_azi;
        end
    end

    assign o_vld = r_vld[2];
    assign o_ctx = r_c_ctx;
    assign o_pol = r_c_pol;
    assign o_azi = r_c_azi;

endmodule

/* design/uv_sphere_grid_point.sv */
// uv sphere grid point: position, texture coordinate and face indices per grid point
// one request per cycle sustained while the skid stage is empty
// the 42 cell divider chain and 7 taylor cells of 3 stages set the depth
// synchronous active low reset clears the pipeline, output and skid stages, and
// loads faces_around 16 and faces_pole_to_pole 8; uses usg_pkg, usg_div_cell, usg_trig_cell
module uv_sphere_grid_point (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  usg_pkg::t_usg_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output usg_pkg::t_usg_out             o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [usg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [usg_pkg::GRID_BITS-1:0] i_cfg_data
);
    import usg_pkg::*;

    localparam int G = GRID_BITS;

    typedef struct packed {
        logic [ANG_W-1:0] a;
        logic [1:0]       quad;
        logic             swap;
    } t_fold;

    typedef struct packed {
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] c;
    } t_sc;

    function automatic t_fold fold(input logic [PHASE_W-1:0] p);
        logic [ANG_W-1:0] f;
        t_fold            res;
        f        = p[ANG_W-1:0];
        res.quad = p[PHASE_W-1:PHASE_W-2];
        res.swap = f[ANG_W-1];
        res.a    = res.swap ? ANG_W'((31'd1 << ANG_W) - {1'b0, f}) : f;
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] tex(input t_usg_dlane l);
        logic        sat;
        logic [OUT_W:0] sum;
        sat = |l.quo[QUO_W-1:PHASE_W];
        sum = {1'b0, l.quo[PHASE_W-1:PHASE_W-OUT_W]} + (OUT_W + 1)'(l.rbit);
        return (sat || sum[OUT_W]) ? {OUT_W{1'b1}} : sum[OUT_W-1:0];
    endfunction

    function automatic t_sc finish(input t_usg_ang g);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W:0] c;
        logic signed [ACC_W-1:0] ss;
        logic signed [ACC_W-1:0] cc;
        t_sc res;
        s = $signed({1'b0, g.sin.pos}) - $signed({1'b0, g.sin.neg});
        c = $signed({1'b0, g.cos.pos}) - $signed({1'b0, g.cos.neg});
        ss = g.swap ? c[ACC_W-1:0] : s[ACC_W-1:0];
        cc = g.swap ? s[ACC_W-1:0] : c[ACC_W-1:0];
        case (g.quad)
            2'd0: begin res.s = ss;  res.c = cc;  end
            2'd1: begin res.s = cc;  res.c = -ss; end
            2'd2: begin res.s = -ss; res.c = -cc; end
            default: begin res.s = -cc; res.c = ss; end
        endcase
        return res;
    endfunction

    // round half away from zero, clamp to +-1.0
    function automatic logic [OUT_W-1:0] to_out(input logic signed [63:0] v, input int sh);
        logic [63:0] mag;
        logic [63:0] lim;
        mag = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        lim = 64'd1 << FRAC_BITS;
        if (mag > lim) begin
            mag = lim;
        end
        return v[63] ? OUT_W'(64'd0 - mag) : OUT_W'(mag);
    endfunction

    // configuration
    logic [G-1:0] r_faces_around;
    logic [G-1:0] r_faces_pole;
    logic [G-1:0] w_fa;
    logic [G-1:0] w_fv;

    assign o_cfg_ready = 1'b1;
    assign w_fa = (r_faces_around == '0) ? G'(1) : r_faces_around;
    assign w_fv = (r_faces_pole == '0) ? G'(1) : r_faces_pole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faces_around <= G'(16);
            r_faces_pole   <= G'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FACES_AROUND: r_faces_around <= i_cfg_data;
                REG_FACES_POLE:   r_faces_pole   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_skid_valid;
    logic r_out_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // entry stage
    logic [2*G:0] w_vi_mul;
    logic [2*G:0] w_fn_mul;
    t_usg_ctx     n_in_ctx;

    assign w_vi_mul = (2*G+1)'(i_in_data.row) * (2*G+1)'({1'b0, w_fa} + (G+1)'(1));
    assign w_fn_mul = (2*G+1)'(i_in_data.row) * (2*G+1)'(w_fa);

    always_comb begin
        n_in_ctx        = '0;
        n_in_ctx.vi     = IDX_W'(w_vi_mul + (2*G+1)'(i_in_data.column));
        n_in_ctx.fnum   = IDX_W'(w_fn_mul + (2*G+1)'(i_in_data.column));
        n_in_ctx.fvalid = (i_in_data.row < w_fv) && (i_in_data.column < w_fa);
        n_in_ctx.pole_n = i_in_data.row == '0;
        n_in_ctx.pole_s = i_in_data.row == w_fv;
    end

    logic       d_vld [DIV_STEPS+1];
    t_usg_ctx   d_ctx [DIV_STEPS+1];
    t_usg_dlane d_row [DIV_STEPS+1];
    t_usg_dlane d_col [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_vld[0] <= 1'b0;
        end else if (w_en) begin
            d_vld[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            d_ctx[0] <= n_in_ctx;
            d_row[0] <= '{num: i_in_data.row, rem: '0, quo: '0, rbit: 1'b0};
            d_col[0] <= '{num: i_in_data.column, rem: '0, quo: '0, rbit: 1'b0};
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        usg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_step  (STEP_W'(g)),
            .i_div_a (w_fa),
            .i_div_v (w_fv),
            .i_vld   (d_vld[g]),
            .i_ctx   (d_ctx[g]),
            .i_row   (d_row[g]),
            .i_col   (d_col[g]),
            .o_vld   (d_vld[g+1]),
            .o_ctx   (d_ctx[g+1]),
            .o_row   (d_row[g+1]),
            .o_col   (d_col[g+1])
        );
    end

    // angle preparation: fold to an octant, scale to radians, square
    logic     r_e1_vld, r_e2_vld, r_e3_vld;
    t_usg_ctx r_e1_ctx, r_e2_ctx, r_e3_ctx;
    t_fold    r_e1_p, r_e1_z;
    t_fold    r_e2_p, r_e2_z;
    t_usg_ang r_e3_p, r_e3_z;
    t_usg_ctx n_e1_ctx;
    logic [PHASE_W-1:0] w_row_phase;
    logic [ANG_W+31:0]  w_xp_p, w_xp_z;
    logic [2*ANG_W-1:0] w_sq_p, w_sq_z;

    assign w_row_phase = {d_row[DIV_STEPS].quo[PHASE_W], d_row[DIV_STEPS].quo[PHASE_W-1:1]};
    assign w_xp_p = (ANG_W+32)'(r_e1_p.a) * (ANG_W+32)'(PI_Q30);
    assign w_xp_z = (ANG_W+32)'(r_e1_z.a) * (ANG_W+32)'(PI_Q30);
    assign w_sq_p = (2*ANG_W)'(r_e2_p.a) * (2*ANG_W)'(r_e2_p.a);
    assign w_sq_z = (2*ANG_W)'(r_e2_z.a) * (2*ANG_W)'(r_e2_z.a);

    always_comb begin
        n_e1_ctx       = d_ctx[DIV_STEPS];
        n_e1_ctx.tex_u = tex(d_col[DIV_STEPS]);
        n_e1_ctx.tex_v = tex(d_row[DIV_STEPS]);
    end

    function automatic t_usg_ang ang_init(input t_fold x, input logic [ANG_W-1:0] x2);
        t_usg_ang res;
        res.x2       = x2;
        res.sin.term = SER_W'(x.a);
        res.sin.pos  = ACC_W'(x.a);
        res.sin.neg  = '0;
        res.cos.term = ONE_Q30;
        res.cos.pos  = ACC_W'(ONE_Q30);
        res.cos.neg  = '0;
        res.quad     = x.quad;
        res.swap     = x.swap;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
            r_e2_vld <= 1'b0;
            r_e3_vld <= 1'b0;
        end else if (w_en) begin
            r_e1_vld <= d_vld[DIV_STEPS];
            r_e2_vld <= r_e1_vld;
            r_e3_vld <= r_e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_ctx <= n_e1_ctx;
            r_e1_p   <= fold(w_row_phase);
            r_e1_z   <= fold(d_col[DIV_STEPS].quo[PHASE_W-1:0]);
            r_e2_ctx <= r_e1_ctx;
            // a field now carries the angle in radians
            r_e2_p   <= '{a: w_xp_p[ANG_W+30:31], quad: r_e1_p.quad, swap: r_e1_p.swap};
            r_e2_z   <= '{a: w_xp_z[ANG_W+30:31], quad: r_e1_z.quad, swap: r_e1_z.swap};
            r_e3_ctx <= r_e2_ctx;
            r_e3_p   <= ang_init(r_e2_p, w_sq_p[2*ANG_W-1:ANG_W]);
            r_e3_z   <= ang_init(r_e2_z, w_sq_z[2*ANG_W-1:ANG_W]);
        end
    end

    logic     t_vld [TERMS+1];
    t_usg_ctx t_ctx [TERMS+1];
    t_usg_ang t_pol [TERMS+1];
    t_usg_ang t_azi [TERMS+1];

    assign t_vld[0] = r_e3_vld;
    assign t_ctx[0] = r_e3_ctx;
    assign t_pol[0] = r_e3_p;
    assign t_azi[0] = r_e3_z;

    for (genvar g = 0; g < TERMS; g++) begin : g_trig
        usg_trig_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_term  (TERM_W'(g)),
            .i_vld   (t_vld[g]),
            .i_ctx   (t_ctx[g]),
            .i_pol   (t_pol[g]),
            .i_azi   (t_azi[g]),
            .o_vld   (t_vld[g+1]),
            .o_ctx   (t_ctx[g+1]),
            .o_pol   (t_pol[g+1]),
            .o_azi   (t_azi[g+1])
        );
    end

    // signs, products, rounding
    logic     r_f_vld, r_g_vld;
    t_usg_ctx r_f_ctx, r_g_ctx;
    t_sc      r_f_p, r_f_z;
    logic signed [63:0] r_g_x, r_g_y, r_g_z;
    t_usg_out n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= t_vld[TERMS];
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_ctx <= t_ctx[TERMS];
            r_f_p   <= finish(t_pol[TERMS]);
            r_f_z   <= finish(t_azi[TERMS]);
            r_g_ctx <= r_f_ctx;
            r_g_x   <= 64'(r_f_p.s) * 64'(r_f_z.c);
            r_g_y   <= 64'(r_f_p.s) * 64'(r_f_z.s);
            r_g_z   <= 64'(r_f_p.c);
        end
    end

    always_comb begin
        logic [IDX_W-1:0] fa_w;
        fa_w = IDX_W'(w_fa);
        n_res.tex_u        = r_g_ctx.tex_u;
        n_res.tex_v        = r_g_ctx.tex_v;
        n_res.vertex_index = r_g_ctx.vi;
        n_res.face_valid   = r_g_ctx.fvalid;
        if (r_g_ctx.pole_n || r_g_ctx.pole_s) begin
            n_res.pos_x = '0;
            n_res.pos_y = '0;
            n_res.pos_z = r_g_ctx.pole_n ? to_out(64'sd1 <<< 30, 30 - FRAC_BITS)
                                         : to_out(-(64'sd1 <<< 30), 30 - FRAC_BITS);
        end else begin
            n_res.pos_x = to_out(r_g_x, 60 - FRAC_BITS);
            n_res.pos_y = to_out(r_g_y, 60 - FRAC_BITS);
            n_res.pos_z = to_out(r_g_z, 30 - FRAC_BITS);
        end
        if (r_g_ctx.fvalid) begin
            n_res.face_number = r_g_ctx.fnum;
            n_res.corner_a    = r_g_ctx.vi;
            n_res.corner_b    = r_g_ctx.vi + fa_w + IDX_W'(1);
            n_res.corner_c    = r_g_ctx.vi + fa_w + IDX_W'(2);
            n_res.corner_d    = r_g_ctx.vi + IDX_W'(1);
        end else begin
            n_res.face_number = '0;
            n_res.corner_a    = '0;
            n_res.corner_b    = '0;
            n_res.corner_c    = '0;
            n_res.corner_d    = '0;
        end
    end

    // output register with skid stage
    t_usg_out r_out;
    t_usg_out r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_g_vld) begin
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (r_g_vld) begin
            if (!r_out_valid || i_out_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output stage is empty");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !r_skid_valid && r_g_vld) |=> r_skid_valid)
        else $error("result lost while output stalled");

    a_no_face_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.face_valid) |->
            (o_out_data.face_number == '0 && o_out_data.corner_b == '0))
        else $error("face fields not cleared without a face");

    a_corner_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.face_valid) |->
            (o_out_data.corner_d == o_out_data.corner_a + IDX_W'(1)))
        else $error("corner d does not follow corner a");
`endif

endmodule

/* tb/uv_sphere_grid_point_test.sv */
// testbench for uv_sphere_grid_point: streams grid points under random idling and
// checks every result against a built-in fixed point model; depends on usg_pkg and the rtl
module uv_sphere_grid_point_test;
    timeunit 1ns;
    timeprecision 1ps;

    import usg_pkg::*;

    localparam longint unsigned PI_Q30_L  = 64'd3373259426;
    localparam longint unsigned ONE_Q30_L = 64'd1 << 30;
    localparam int              LATENCY   = 70;
    localparam longint          MAX_CYCLES = 64'd400000;

    int errors;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // reference style octant sine/cosine in q30, a is at most an eighth turn
    function automatic void octant_trig(input longint unsigned a, output longint s,
                                        output longint c);
        longint unsigned x, x2, term, pos, neg;
        x = (a * PI_Q30_L) >> 31;
        x2 = (x * x) >> 30;
        term = x; pos = x; neg = 0;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k & 1) neg += term; else pos += term;
        end
        s = longint'(pos) - longint'(neg);
        term = ONE_Q30_L; pos = ONE_Q30_L; neg = 0;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k & 1) neg += term; else pos += term;
        end
        c = longint'(pos) - longint'(neg);
    endfunction

    function automatic void phase_trig(input logic [31:0] p, output longint s,
                                       output longint c);
        logic [1:0] q;
        longint unsigned f;
        longint ss, cc;
        q = p[31:30];
        f = p[29:0];
        if (f < (64'd1 << 29)) octant_trig(f, ss, cc);
        else octant_trig((64'd1 << 30) - f, cc, ss);
        case (q)
            2'd0: begin s = ss;  c = cc;  end
            2'd1: begin s = cc;  c = -ss; end
            2'd2: begin s = -ss; c = -cc; end
            default: begin s = -cc; c = ss; end
        endcase
    endfunction

    function automatic logic [15:0] round_clamp(input longint v, input int sh);
        logic neg;
        longint unsigned mag;
        neg = v < 0;
        mag = neg ? longint'(-v) : v;
        if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (mag > (64'd1 << FRAC_BITS)) mag = 64'd1 << FRAC_BITS;
        return neg ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic logic [15:0] tex_coord(input longint unsigned n, input longint unsigned d);
        longint unsigned t;
        t = (n * 65536 + d / 2) / d;
        return t > 65535 ? 16'hFFFF : 16'(t);
    endfunction

    class grid_scoreboard;
        logic [GRID_BITS-1:0] faces_around = 16;
        logic [GRID_BITS-1:0] faces_pole = 8;
        t_usg_out pending[$];

        function t_usg_out grid_point(input t_usg_in req);
            t_usg_out r;
            longint unsigned row, col, fa, fv, vi;
            longint sp, cp, sa, ca;
            row = req.row; col = req.column;
            fa = faces_around ? faces_around : 1;
            fv = faces_pole ? faces_pole : 1;
            vi = row * (fa + 1) + col;
            r = '0;
            if (row == 0 || row == fv) begin
                r.pos_z = round_clamp(row == 0 ? ONE_Q30_L : -longint'(ONE_Q30_L), 30 - FRAC_BITS);
            end else begin
                phase_trig(32'((row << 31) / fv), sp, cp);
                phase_trig(32'((col << 32) / fa), sa, ca);
                r.pos_x = round_clamp(sp * ca, 60 - FRAC_BITS);
                r.pos_y = round_clamp(sp * sa, 60 - FRAC_BITS);
                r.pos_z = round_clamp(cp, 30 - FRAC_BITS);
            end
            r.tex_u = tex_coord(col, fa);
            r.tex_v = tex_coord(row, fv);
            r.vertex_index = 20'(vi);
            r.face_valid = row < fv && col < fa;
            if (r.face_valid) begin
                r.face_number = 20'(row * fa + col);
                r.corner_a = 20'(vi);
                r.corner_b = 20'(vi + fa + 1);
                r.corner_c = 20'(vi + fa + 2);
                r.corner_d = 20'(vi + 1);
            end
            return r;
        endfunction

        function void note_request(input t_usg_in req);
            pending.push_back(grid_point(req));
        endfunction

        task check_result(input t_usg_out got);
            t_usg_out w;
            if (pending.size() == 0) begin
                $display("unexpected result");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.pos_x !== w.pos_x) report_mismatch("pos_x", got.pos_x, w.pos_x);
            if (got.pos_y !== w.pos_y) report_mismatch("pos_y", got.pos_y, w.pos_y);
            if (got.pos_z !== w.pos_z) report_mismatch("pos_z", got.pos_z, w.pos_z);
            if (got.tex_u !== w.tex_u) report_mismatch("tex_u", got.tex_u, w.tex_u);
            if (got.tex_v !== w.tex_v) report_mismatch("tex_v", got.tex_v, w.tex_v);
            if (got.vertex_index !== w.vertex_index)
                report_mismatch("vertex_index", got.vertex_index, w.vertex_index);
            if (got.face_valid !== w.face_valid)
                report_mismatch("face_valid", got.face_valid, w.face_valid);
            if (got.face_number !== w.face_number)
                report_mismatch("face_number", got.face_number, w.face_number);
            if (got.corner_a !== w.corner_a) report_mismatch("corner_a", got.corner_a, w.corner_a);
            if (got.corner_b !== w.corner_b) report_mismatch("corner_b", got.corner_b, w.corner_b);
            if (got.corner_c !== w.corner_c) report_mismatch("corner_c", got.corner_c, w.corner_c);
            if (got.corner_d !== w.corner_d) report_mismatch("corner_d", got.corner_d, w.corner_d);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, o_in_ready;
    t_usg_in i_in_data = '0;
    logic o_out_valid, i_out_ready = 0;
    t_usg_out o_out_data;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_FACES_AROUND;
    logic [GRID_BITS-1:0] i_cfg_data = '0;

    grid_scoreboard board = new();
    longint cycles;

    uv_sphere_grid_point i_dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall per result
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_out_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1;
            @(posedge i_clk iff o_out_valid);
            board.check_result(o_out_data);
        end
    end

    task automatic send_point(input logic [GRID_BITS-1:0] r, input logic [GRID_BITS-1:0] c,
                              input bit idle);
        t_usg_in req;
        int gap;
        gap = idle ? $urandom_range(0, 13) : 0;
        req.row = r; req.column = c;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= req;
        @(posedge i_clk iff o_in_ready);
        board.note_request(req);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_BITS-1:0] val);
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == REG_FACES_AROUND) board.faces_around = val;
        else board.faces_pole = val;
    endtask

    initial begin
        logic [GRID_BITS-1:0] fa_set[6] = '{16, 1, 1023, 0, 7, 100};
        logic [GRID_BITS-1:0] fv_set[6] = '{8, 1023, 1, 0, 12, 3};
        bit idle;
        int lim_r, lim_c;
        errors = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: poles, past the grid, extremes
        send_point(0, 0, 0);
        send_point(8, 16, 0);
        send_point(7, 15, 0);
        send_point(4, 4, 0);
        send_point(9, 17, 0);
        send_point(1023, 1023, 0);
        send_point(0, 1023, 0);
        send_point(1023, 0, 0);
        send_point(2, 8, 0);
        send_point(6, 12, 0);
        send_point(10'h2AA, 10'h155, 0);
        send_point(10'h155, 10'h2AA, 0);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(REG_FACES_AROUND, fa_set[ph]);
                write_reg(REG_FACES_POLE, fv_set[ph]);
            end
            lim_r = fv_set[ph] == 0 ? 1 : fv_set[ph];
            lim_c = fa_set[ph] == 0 ? 1 : fa_set[ph];
            for (int n = 0; n < 225; n++) begin
                idle = (n / 40) % 2 == 1;
                if ($urandom_range(0, 9) < 8)
                    send_point($urandom_range(0, lim_r), $urandom_range(0, lim_c), idle);
                else
                    send_point($urandom_range(0, 1023), $urandom_range(0, 1023), idle);
            end
        end
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

/* uv_sphere_grid_point.f */
design/usg_pkg.sv
design/usg_div_cell.sv
design/usg_trig_cell.sv
design/uv_sphere_grid_point.sv
tb/uv_sphere_grid_point_test.sv
